// ===== rtl/ssws_pkg.sv =====
// Shared types and constants for the slope-sensitive window smoother.
// No dependencies; imported by slope_sensitive_window_smoother_core.
`default_nettype none

package ssws_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int SENS_W    = 24;

  localparam logic [SAMPLE_W-1:0] ONE_Q15        = 16'd32768;
  localparam logic [SAMPLE_W-1:0] HALF_Q15       = 16'd16384;
  localparam logic [SAMPLE_W-1:0] RATE_FLOOR_Q15 = 16'd262;   // 0.008

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_MUL1,
    S_MUL2,
    S_RATE,
    S_MUL3,
    S_OUT
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/slope_sensitive_window_smoother_core.sv =====
// Slope-sensitive window smoother: ring memory, running sum, reciprocal-multiply average,
//   rate/follow math. Depends on ssws_pkg.
// An accepted sample beat steps through every state from S_SUM to S_OUT before its result is in the output register.
// One sample per pass: idle (takes the beat), sum, window average, two registered multiplies, rate,
//   a third multiply, output load; no new sample is taken mid-pass, and a stalled result holds the last step.
// The output register holds a finished beat while the next sample is taken in.
// Reset: asynchronous, active low; ring reads as 0.5 until each slot is first written
//   (wrap flag, no clearing pass); the previous output last_q starts at 0.5 and the running sum at 0.5 per entry.
`default_nettype none

module slope_sensitive_window_smoother_core
  import ssws_pkg::*;
#(
  parameter int WINDOW_LENGTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [SENS_W-1:0]   cfg_slope_sensitivity_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [SAMPLE_W-1:0]      smoothed_o
);

  localparam int DIV_D       = WINDOW_LENGTH + 1;
  localparam int CW          = $clog2(DIV_D);
  localparam int NUM_W       = SAMPLE_W + CW;
  localparam int RW          = NUM_W + 1;
  localparam int RECIP_SHIFT = NUM_W + CW;
  localparam int AW          = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

  localparam logic [NUM_W-1:0]  SUM_RESET  = NUM_W'(WINDOW_LENGTH * 16384);
  localparam logic [NUM_W-1:0]  HALF_DIV   = NUM_W'(DIV_D / 2);
  // ceil(2^RECIP_SHIFT / DIV_D): exact floor division for any NUM_W-bit numerator
  localparam logic [RW-1:0]     RECIP      =
    RW'(((64'd1 << RECIP_SHIFT) + 64'(DIV_D) - 64'd1) / 64'(DIV_D));
  localparam logic [AW-1:0]     LAST_SLOT  = AW'(WINDOW_LENGTH - 1);
  localparam logic [SENS_W-1:0] SENS_RESET =
    SENS_W'((6000 * 256 * 2 + DIV_D) / (2 * DIV_D));

  state_e state_q, state_d;

  logic [SAMPLE_W-1:0]   ring_mem [WINDOW_LENGTH];
  logic [SAMPLE_W-1:0]   rd_q;
  logic [AW-1:0]         slot_q;
  logic                  wrapped_q;
  logic [NUM_W-1:0]      sum_q;
  logic [SENS_W-1:0]     sens_q;
  logic [SAMPLE_W-1:0]   last_q;
  logic [SAMPLE_W-1:0]   x_q;
  logic [NUM_W-1:0]      num_q;
  logic [NUM_W+RW-1:0]   avg_prod_q;
  logic [39:0]           prod1_q;
  logic                  sat_q;
  logic [45:0]           sq_q;
  logic [SAMPLE_W-1:0]   keep_q;
  logic [31:0]           prod3_q;
  logic                  dneg_q;
  logic                  out_valid_q;
  logic [SAMPLE_W-1:0]   out_data_q;

  logic                in_accept;
  logic                out_load;
  logic                ring_we;
  logic [SAMPLE_W-1:0] old_word;
  logic [NUM_W-1:0]    num;
  logic [SAMPLE_W-1:0] avg;
  logic [16:0]         adiff;
  logic [16:0]         adiff_neg;
  logic [15:0]         amag;
  logic [46:0]         sq_rnd;
  logic [SAMPLE_W-1:0] rate;
  logic [16:0]         odiff;
  logic [16:0]         odiff_neg;
  logic [15:0]         omag;
  logic [32:0]         prod3_rnd;
  logic [17:0]         step_mag;
  logic [18:0]         y_full;
  logic [SAMPLE_W-1:0] y_clamped;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d    = state_q;
    in_stall_o = (state_q != S_IDLE);
    out_load   = 1'b0;
    ring_we    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SUM;
      end
      S_SUM: begin
        ring_we = 1'b1;
        state_d = S_DIV;
      end
      S_DIV:  state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_RATE;
      S_RATE: state_d = S_MUL3;
      S_MUL3: state_d = S_OUT;
      S_OUT: begin
        // wait while a previous result is still held by a stalled sink
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- ring memory ----------------
  // Read is issued at the accept edge; the write to the same slot comes at the end of S_SUM,
  // and the next read comes only with the next item, so no forwarding.
  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[slot_q] <= x_q;
    rd_q <= ring_mem[slot_q];
  end

  assign old_word = wrapped_q ? rd_q : HALF_Q15;
  assign num      = sum_q + NUM_W'(x_q) + HALF_DIV;
  assign avg      = avg_prod_q[RECIP_SHIFT +: SAMPLE_W];

  // ---------------- combinational datapath ----------------
  always_comb begin
    adiff     = {1'b0, avg} - {1'b0, last_q};
    adiff_neg = 17'd0 - adiff;
    amag      = adiff[16] ? adiff_neg[15:0] : adiff[15:0];

    sq_rnd = {1'b0, sq_q} + 47'(64'd1 << 30);
    rate   = sq_rnd[46:31];
    if (sat_q) rate = ONE_Q15;
    if (rate < RATE_FLOOR_Q15) rate = RATE_FLOOR_Q15;
    if (rate > ONE_Q15) rate = ONE_Q15;

    odiff     = {1'b0, last_q} - {1'b0, x_q};
    odiff_neg = 17'd0 - odiff;
    omag      = odiff[16] ? odiff_neg[15:0] : odiff[15:0];

    prod3_rnd = {1'b0, prod3_q} + 33'(64'd1 << 14);
    step_mag  = prod3_rnd[32:15];
    y_full    = dneg_q ? ({3'b000, x_q} - {1'b0, step_mag})
                       : ({3'b000, x_q} + {1'b0, step_mag});
    if (y_full[18]) begin
      y_clamped = '0;
    end else if (y_full > {3'b000, ONE_Q15}) begin
      y_clamped = ONE_Q15;
    end else begin
      y_clamped = y_full[15:0];
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      wrapped_q   <= 1'b0;
      sum_q       <= SUM_RESET;
      last_q      <= HALF_Q15;
      sens_q      <= SENS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) sens_q <= cfg_slope_sensitivity_i;
      if (state_q == S_SUM) begin
        sum_q <= sum_q - NUM_W'(old_word) + NUM_W'(x_q);
        if (slot_q == LAST_SLOT) begin
          slot_q    <= '0;
          wrapped_q <= 1'b1;
        end else begin
          slot_q <= slot_q + 1'b1;
        end
      end
      if (out_load) begin
        last_q      <= y_clamped;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (in_accept) x_q <= sample_i;
    case (state_q)
      S_SUM:  num_q <= num;
      // window average: multiply by the reciprocal, quotient sits above RECIP_SHIFT
      S_DIV:  avg_prod_q <= num_q * RECIP;
      S_MUL1: prod1_q <= sens_q * amag;
      S_MUL2: begin
        sat_q <= |prod1_q[39:23];
        sq_q  <= prod1_q[22:0] * prod1_q[22:0];
      end
      S_RATE: keep_q <= ONE_Q15 - rate;
      S_MUL3: begin
        prod3_q <= keep_q * omag;
        dneg_q  <= odiff[16];
      end
      default: ;
    endcase
    if (out_load) out_data_q <= y_clamped;
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign smoothed_o  = out_data_q;

  // ---------------- assertions ----------------
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= LAST_SLOT)
    else $error("ring slot out of range");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result beat without finishing sequence");

  a_out_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q <= ONE_Q15)
    else $error("result above 1.0");

  a_avg_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |=> state_q == S_MUL1)
    else $error("average step did not advance");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q && $stable(out_data_q))
    else $error("held result changed under stall");

endmodule

`default_nettype wire
